/* hw/rtl/ilt_pkg.sv */
// Shared types and constants for the indentation level tracker.
// Holds the request and response payloads, status codes, controller states
// and the command and flag bundles between controller and datapath.
`default_nettype none

package ilt_pkg;

   // Fixed field widths of the request and response payloads.
   localparam int COLUMN_WIDTH = 10;
   localparam int STATUS_WIDTH = 3;
   localparam int DEPTH_WIDTH  = 6;

   // Default sizes of the indentation stack.
   localparam int MAX_LEVELS_DEF  = 32;
   localparam int COLUMN_BITS_DEF = 10;

   // Result status codes.
   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_OK             = 3'd0,
      ST_TOP_INDENTED   = 3'd1,
      ST_INCONSISTENT   = 3'd2,
      ST_DEPTH_EXCEEDED = 3'd3,
      ST_UNEXPECTED     = 3'd4
   } ilt_status_type;

   // Controller states.
   typedef enum logic [1:0] {
      S_IDLE,
      S_EVAL,
      S_SCAN
   } ilt_state_type;

   // One request: a source line.
   typedef struct packed {
      logic [COLUMN_WIDTH-1:0] column;
      logic                    opens_block;
   } ilt_req_type;

   // One response: status and new stack depth.
   typedef struct packed {
      logic [STATUS_WIDTH-1:0] status;
      logic [DEPTH_WIDTH-1:0]  depth;
   } ilt_rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic           load;
      logic           push;
      logic           pop;
      logic           scan_init;
      logic           scan_step;
      logic           respond;
      ilt_status_type status;
   } ilt_cmd_type;

   // Flags from the datapath to the controller.
   typedef struct packed {
      logic empty;
      logic depth_one;
      logic full;
      logic col_is_one;
      logic col_eq_top;
      logic col_gt_top;
      logic opener;
      logic scan_eq;
      logic scan_lt;
      logic idx_zero;
   } ilt_flags_type;

endpackage

`default_nettype wire

/* hw/rtl/ilt_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; used for the column stack of the indentation tracker.
`default_nettype none

module ilt_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hw/rtl/ilt_datapath.sv */
// Datapath of the indentation tracker: request registers, top-of-stack and
// depth registers, scan index, column stack RAM and response register.
// Depends on ilt_pkg and ilt_ram.
`default_nettype none

module ilt_datapath
   import ilt_pkg::*;
#(
   parameter int MAX_LEVELS  = MAX_LEVELS_DEF,
   parameter int COLUMN_BITS = COLUMN_BITS_DEF
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire ilt_req_type   req_data,
   input  wire ilt_cmd_type   cmd,
   output ilt_flags_type      flags,
   output ilt_rsp_type        rsp_data,
   output logic               rsp_strobe
);

   localparam int AW = $clog2(MAX_LEVELS);
   localparam int DW = $clog2(MAX_LEVELS + 1);

   logic [COLUMN_BITS-1:0] col_ff, col_in;
   logic                   opener_ff, opener_in;
   logic [COLUMN_BITS-1:0] top_ff, top_in;
   logic [DW-1:0]          depth_ff, depth_in;
   logic [AW-1:0]          idx_ff, idx_in;
   ilt_rsp_type            rsp_ff, rsp_in;
   logic                   rsp_strobe_ff, rsp_strobe_in;

   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   logic [AW-1:0]          rd_addr;
   logic [COLUMN_BITS-1:0] rd_data;
   logic [AW-1:0]          scan_start;

   // The scan starts at the entry just below the top.
   assign scan_start = AW'(depth_ff - DW'(2));

   // Next-state logic for the stack and request registers.
   always_comb begin
      col_in        = col_ff;
      opener_in     = opener_ff;
      top_in        = top_ff;
      depth_in      = depth_ff;
      idx_in        = idx_ff;
      wr_en         = 1'b0;
      wr_addr       = AW'(depth_ff);
      rsp_in        = rsp_ff;
      rsp_strobe_in = cmd.respond;

      if (cmd.load) begin
         col_in    = COLUMN_BITS'(req_data.column);
         opener_in = req_data.opens_block;
      end

      if (cmd.push) begin
         wr_en    = 1'b1;
         top_in   = col_ff;
         depth_in = depth_ff + DW'(1);
      end

      if (cmd.pop) begin
         top_in   = col_ff;
         depth_in = DW'(idx_ff) + DW'(1);
      end

      if (cmd.scan_init) begin
         idx_in = scan_start;
      end else if (cmd.scan_step) begin
         idx_in = idx_ff - AW'(1);
      end

      if (cmd.respond) begin
         rsp_in.status = cmd.status;
         rsp_in.depth  = DEPTH_WIDTH'(depth_in);
      end
   end

   // Read one entry ahead of the compare so the scan takes one entry a cycle.
   assign rd_addr = cmd.scan_init ? scan_start : idx_ff - AW'(1);

   // Control registers are reset; payload registers are not.
   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         depth_ff      <= depth_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      col_ff    <= col_in;
      opener_ff <= opener_in;
      top_ff    <= top_in;
      idx_ff    <= idx_in;
      rsp_ff    <= rsp_in;
   end

   ilt_ram #(
      .WIDTH (COLUMN_BITS),
      .DEPTH (MAX_LEVELS)
   ) u_stack (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (col_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Flags for the controller.
   always_comb begin
      flags.empty      = (depth_ff == '0);
      flags.depth_one  = (depth_ff == DW'(1));
      flags.full       = (depth_ff == DW'(MAX_LEVELS));
      flags.col_is_one = (col_ff == COLUMN_BITS'(1));
      flags.col_eq_top = (col_ff == top_ff);
      flags.col_gt_top = (col_ff > top_ff);
      flags.opener     = opener_ff;
      flags.scan_eq    = (rd_data == col_ff);
      flags.scan_lt    = (rd_data < col_ff);
      flags.idx_zero   = (idx_ff == '0);
   end

   assign rsp_data   = rsp_ff;
   assign rsp_strobe = rsp_strobe_ff;

endmodule

`default_nettype wire

/* hw/rtl/ilt_controller.sv */
// Controller of the indentation tracker: decides each line's outcome from
// the datapath flags and steps the dedent scan. Depends on ilt_pkg.
`default_nettype none

module ilt_controller
   import ilt_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire ilt_flags_type flags,
   output logic               busy,
   output ilt_cmd_type        cmd
);

   ilt_state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.status = ST_OK;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_EVAL;
            end
         end

         S_EVAL: begin
            state_in    = S_IDLE;
            cmd.respond = 1'b1;
            if (flags.empty) begin
               // Only column one may open the top level.
               if (flags.col_is_one) begin
                  cmd.push = 1'b1;
               end else begin
                  cmd.status = ST_TOP_INDENTED;
               end
            end else if (flags.col_eq_top) begin
               cmd.status = ST_OK;
            end else if (flags.col_gt_top) begin
               // Full is checked before the block opener flag.
               if (flags.full) begin
                  cmd.status = ST_DEPTH_EXCEEDED;
               end else if (!flags.opener) begin
                  cmd.status = ST_UNEXPECTED;
               end else begin
                  cmd.push = 1'b1;
               end
            end else if (flags.depth_one) begin
               cmd.status = ST_INCONSISTENT;
            end else begin
               // Dedent: search the entries below the top.
               cmd.respond   = 1'b0;
               cmd.scan_init = 1'b1;
               state_in      = S_SCAN;
            end
         end

         S_SCAN: begin
            if (flags.scan_eq) begin
               cmd.pop     = 1'b1;
               cmd.respond = 1'b1;
               state_in    = S_IDLE;
            end else if (flags.scan_lt || flags.idx_zero) begin
               cmd.status  = ST_INCONSISTENT;
               cmd.respond = 1'b1;
               state_in    = S_IDLE;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != S_IDLE);

endmodule

`default_nettype wire

/* hw/rtl/indentation_level_tracker_unit.sv */
// Top level of the indentation level tracker.
// Joins the controller and the datapath; depends on ilt_pkg and submodules.
//
// Usage:
//   A request (one source line: start column and block-opener flag) is taken
//   on req_data at a rising edge where start is high and busy is low.
//   Each request gives exactly one response on rsp_data (status and new
//   stack depth), shown for one cycle with rsp_strobe high. The receiver
//   cannot stall; the response must be taken in that cycle.
//   A line that needs no dedent search keeps busy high for one cycle, and a
//   new line is taken only once busy is low again. A dedent searches the
//   stack RAM one entry per cycle from just below the top, through the
//   single read port of the column stack, and busy stays high meanwhile.
//   Reset empties the stack (depth zero) and returns the controller to idle;
//   no clearing pass is needed, as only entries below the depth are read.
`default_nettype none

module indentation_level_tracker_unit
   import ilt_pkg::*;
#(
   parameter int MAX_LEVELS  = MAX_LEVELS_DEF,
   parameter int COLUMN_BITS = COLUMN_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire ilt_req_type req_data,
   output ilt_rsp_type      rsp_data,
   output logic             rsp_strobe
);

   ilt_cmd_type   cmd;
   ilt_flags_type flags;

   ilt_controller u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .flags (flags),
      .busy  (busy),
      .cmd   (cmd)
   );

   ilt_datapath #(
      .MAX_LEVELS  (MAX_LEVELS),
      .COLUMN_BITS (COLUMN_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .cmd        (cmd),
      .flags      (flags),
      .rsp_data   (rsp_data),
      .rsp_strobe (rsp_strobe)
   );

endmodule

`default_nettype wire
